>>> src/raf_pkg.sv
package raf_pkg;

  // Fixed-point scale of the running sum and the average (times 256).
  localparam int SCALE_SHIFT = 8;

  // Input command codes.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Sequencer states of the filter.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_LOAD,
    ST_DIV_WAIT,
    ST_TRIM,
    ST_TRIM_WAIT,
    ST_EMIT
  } raf_state_t;

endpackage

>>> src/raf_in_if.sv
interface raf_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, command, sample, input ready);
  modport sink   (input valid, command, sample, output ready);
endinterface

>>> src/raf_out_if.sv
interface raf_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;

  modport source (output valid, average, input ready);
  modport sink   (input valid, average, output ready);
endinterface

>>> src/raf_divider.sv
// Radix-2 restoring divider for unsigned magnitudes. One quotient bit is
// produced per cycle; the dividend shifts out at the top of a shift register
// while quotient bits shift in at the bottom.
module raf_divider #(
  parameter int DIVIDEND_BITS = 41,
  parameter int DIVISOR_BITS  = 17,
  parameter int QUOTIENT_BITS = 25
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic                     done,
  output logic [QUOTIENT_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic                     busy;
  logic [CNT_BITS-1:0]      cnt;
  logic [DIVIDEND_BITS-1:0] dq;
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVISOR_BITS-1:0]  dvs;
  logic [DIVISOR_BITS:0]    rem_shifted;
  logic [DIVISOR_BITS:0]    diff;
  logic                     qbit;

  // Trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    rem_shifted = {rem, dq[DIVIDEND_BITS-1]};
    diff        = rem_shifted - {1'b0, dvs};
    qbit        = ~diff[DIVISOR_BITS];
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DIVIDEND_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and dividend/quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= {dq[DIVIDEND_BITS-2:0], qbit};
      rem <= qbit ? diff[DIVISOR_BITS-1:0] : rem_shifted[DIVISOR_BITS-1:0];
    end
  end

  assign quotient = dq[QUOTIENT_BITS-1:0];

  // The partial remainder stays below the divisor throughout a division.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem < dvs))
    else $error("divider remainder not below divisor");

endmodule

>>> src/raf_msub.sv
// Shift-and-subtract unit: result = base - multiplier * multiplicand.
// One multiplier bit is consumed per cycle, LSB first, and the unit stops
// as soon as no set bits remain.
module raf_msub #(
  parameter int ACC_BITS  = 41,
  parameter int MULT_BITS = 17,
  parameter int MCND_BITS = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [ACC_BITS-1:0]  base,
  input  logic        [MULT_BITS-1:0] multiplier,
  input  logic signed [MCND_BITS-1:0] multiplicand,
  output logic                        done,
  output logic signed [ACC_BITS-1:0]  result
);

  logic                 busy;
  logic [MULT_BITS-1:0] mult;
  logic [ACC_BITS-1:0]  addend;

  // Step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (mult == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Accumulator, shifted multiplicand and remaining multiplier bits.
  always_ff @(posedge clk) begin
    if (start) begin
      result <= base;
      mult   <= multiplier;
      addend <= {{(ACC_BITS-MCND_BITS){multiplicand[MCND_BITS-1]}}, multiplicand};
    end else if (busy && (mult != '0)) begin
      if (mult[0]) begin
        result <= result - $signed(addend);
      end
      addend <= {addend[ACC_BITS-2:0], 1'b0};
      mult   <= {1'b0, mult[MULT_BITS-1:1]};
    end
  end

endmodule

>>> src/running_average_filter_unit.sv
// Running average filter. Each sample transaction on feed adds sample*256 to
// a running sum and returns on result the sum divided by the fill count,
// divided by 256 and truncated toward zero; once the fill count passes
// window_length the excess is taken out of the sum in one step, so the
// filter moves from a cumulative mean to an exponential moving average. A
// clear transaction zeroes sum, count and average and returns nothing. One
// sample is processed at a time: the next one is taken only once the
// radix-2 divider, which produces one quotient bit per cycle over the full
// sum width, has finished and the result has been handed off. When the fill
// count must be trimmed, the shift-and-subtract unit runs in between until
// no set bits of the excess remain. A waiting result does not block the next
// sample; only the final hand-off waits for the result register to be free.
module running_average_filter_unit #(
  parameter int SAMPLE_BITS = 16,
  parameter int WINDOW_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  raf_in_if.sink                 feed,
  raf_out_if.source              result,
  input  logic                   window_length_we,
  input  logic [WINDOW_BITS-1:0] window_length_data
);

  localparam int SHIFT      = raf_pkg::SCALE_SHIFT;
  localparam int SUM_BITS   = SAMPLE_BITS + SHIFT + WINDOW_BITS + 1;
  localparam int COUNT_BITS = WINDOW_BITS + 1;
  localparam int AVG_BITS   = SAMPLE_BITS + SHIFT + 1;

  raf_pkg::raf_state_t state;
  raf_pkg::raf_state_t state_next;

  logic [WINDOW_BITS-1:0]       window;
  logic signed [SUM_BITS-1:0]   sum;
  logic [COUNT_BITS-1:0]        count;
  logic signed [AVG_BITS-1:0]   avg;

  logic                         in_accept;
  logic                         is_clear;
  logic signed [SUM_BITS-1:0]   sample_scaled;
  logic [SUM_BITS-1:0]          sum_mag;
  logic                         over_window;
  logic [COUNT_BITS-1:0]        excess;

  logic                         div_start;
  logic                         div_done;
  logic [AVG_BITS-1:0]          div_quotient;
  logic signed [AVG_BITS-1:0]   avg_next;

  logic                         msub_start;
  logic                         msub_done;
  logic signed [SUM_BITS-1:0]   msub_result;

  logic                         out_load;
  logic [AVG_BITS-1:0]          avg_mag;
  logic [SAMPLE_BITS-1:0]       out_mag;
  logic signed [SAMPLE_BITS-1:0] out_value;

  // Window register; a zero write is stored as one.
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_BITS'(8);
    end else if (window_length_we) begin
      window <= (window_length_data == '0) ? WINDOW_BITS'(1) : window_length_data;
    end
  end

  // Input decode, scaled sample and trim test.
  always_comb begin
    in_accept     = feed.valid && feed.ready;
    is_clear      = (feed.command == raf_pkg::CMD_CLEAR);
    sample_scaled = {{(SUM_BITS-SAMPLE_BITS-SHIFT){feed.sample[SAMPLE_BITS-1]}},
                     feed.sample, SHIFT'(0)};
    sum_mag       = sum[SUM_BITS-1] ? (SUM_BITS'(0) - sum) : sum;
    over_window   = (count > {1'b0, window});
    excess        = count - {1'b0, window};
    avg_next      = sum[SUM_BITS-1] ? (AVG_BITS'(0) - div_quotient) : div_quotient;
  end

  // Output value: scaled average over 256, truncated toward zero.
  always_comb begin
    avg_mag   = avg[AVG_BITS-1] ? (AVG_BITS'(0) - avg) : avg;
    out_mag   = avg_mag[AVG_BITS-2:SHIFT];
    out_value = avg[AVG_BITS-1] ? (SAMPLE_BITS'(0) - out_mag) : out_mag;
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= raf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control strobes.
  always_comb begin
    state_next = state;
    feed.ready = 1'b0;
    div_start  = 1'b0;
    msub_start = 1'b0;
    out_load   = 1'b0;
    case (state)
      raf_pkg::ST_IDLE: begin
        feed.ready = 1'b1;
        if (feed.valid && !is_clear) begin
          state_next = raf_pkg::ST_DIV_LOAD;
        end
      end
      raf_pkg::ST_DIV_LOAD: begin
        div_start  = 1'b1;
        state_next = raf_pkg::ST_DIV_WAIT;
      end
      raf_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = raf_pkg::ST_TRIM;
        end
      end
      raf_pkg::ST_TRIM: begin
        if (over_window) begin
          msub_start = 1'b1;
          state_next = raf_pkg::ST_TRIM_WAIT;
        end else begin
          state_next = raf_pkg::ST_EMIT;
        end
      end
      raf_pkg::ST_TRIM_WAIT: begin
        if (msub_done) begin
          state_next = raf_pkg::ST_EMIT;
        end
      end
      raf_pkg::ST_EMIT: begin
        if (!result.valid || result.ready) begin
          out_load   = 1'b1;
          state_next = raf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = raf_pkg::ST_IDLE;
      end
    endcase
  end

  // Filter state: sum, fill count and scaled average.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
      avg   <= '0;
    end else begin
      if (in_accept) begin
        if (is_clear) begin
          sum   <= '0;
          count <= '0;
          avg   <= '0;
        end else begin
          sum   <= sum + sample_scaled;
          count <= count + COUNT_BITS'(1);
        end
      end
      if ((state == raf_pkg::ST_DIV_WAIT) && div_done) begin
        avg <= avg_next;
      end
      if (msub_start) begin
        count <= {1'b0, window};
      end
      if ((state == raf_pkg::ST_TRIM_WAIT) && msub_done) begin
        sum <= msub_result;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.average <= out_value;
    end
  end

  // Serial divider: |sum| / count.
  raf_divider #(
    .DIVIDEND_BITS (SUM_BITS),
    .DIVISOR_BITS  (COUNT_BITS),
    .QUOTIENT_BITS (AVG_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Serial trim: sum - excess * average.
  raf_msub #(
    .ACC_BITS  (SUM_BITS),
    .MULT_BITS (COUNT_BITS),
    .MCND_BITS (AVG_BITS)
  ) u_msub (
    .clk          (clk),
    .rst          (rst),
    .start        (msub_start),
    .base         (sum),
    .multiplier   (excess),
    .multiplicand (avg),
    .done         (msub_done),
    .result       (msub_result)
  );

  // A clear transaction leaves an empty filter behind.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_accept && is_clear) |=> ((sum == '0) && (count == '0) && (avg == '0)))
    else $error("clear did not empty the filter");

  // By the time a result is emitted the fill count is within the window.
  a_count_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == raf_pkg::ST_EMIT) |-> (count <= {1'b0, window}))
    else $error("fill count above window at result");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == raf_pkg::ST_DIV_WAIT))
    else $error("divider finished outside its wait state");

endmodule

>>> tb/running_average_checker.sv
// Watches the feed and result channels of the running average filter, keeps
// its own copy of the filter state and compares every result transaction
// with the oldest predicted average.
module running_average_checker #(
  parameter int SAMPLE_BITS = 16,
  parameter int WINDOW_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          feed_valid,
  input  logic                          feed_ready,
  input  logic                          feed_command,
  input  logic signed [SAMPLE_BITS-1:0] feed_sample,
  input  logic                          result_valid,
  input  logic                          result_ready,
  input  logic signed [SAMPLE_BITS-1:0] result_average,
  input  logic                          window_length_we,
  input  logic [WINDOW_BITS-1:0]        window_length_data,
  output int                            outstanding,
  output int                            error_count
);

  localparam longint SCALE = longint'(1) << raf_pkg::SCALE_SHIFT;
  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the filter state.
  longint run_sum;
  int     fill_cnt;
  longint avg_scaled;
  int     window_len;

  logic signed [SAMPLE_BITS-1:0] expected_avg_q[$];
  int errors;

  // Adds one sample to the running sum and returns the new average.
  function automatic logic signed [SAMPLE_BITS-1:0] filter_sample(
    input logic signed [SAMPLE_BITS-1:0] smp
  );
    longint excess;
    run_sum    = run_sum + longint'(smp) * SCALE;
    fill_cnt   = fill_cnt + 1;
    avg_scaled = run_sum / longint'(fill_cnt);
    // Once the count is past the window, take the whole excess out at once.
    if (fill_cnt > window_len) begin
      excess   = longint'(fill_cnt - window_len);
      run_sum  = run_sum - excess * avg_scaled;
      fill_cnt = window_len;
    end
    return SAMPLE_BITS'(avg_scaled / SCALE);
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_BITS-1:0] want;
    if (rst) begin
      run_sum    = 0;
      fill_cnt   = 0;
      avg_scaled = 0;
      window_len = 8;
      errors     = 0;
      expected_avg_q.delete();
    end else begin
      // A window written as zero is stored as one.
      if (window_length_we) begin
        window_len = (window_length_data == '0) ? 1 : int'(window_length_data);
      end

      // Each accepted feed transaction updates the shadow state.
      if (feed_valid && feed_ready) begin
        if (feed_command == raf_pkg::CMD_CLEAR) begin
          run_sum    = 0;
          fill_cnt   = 0;
          avg_scaled = 0;
        end else begin
          expected_avg_q.push_back(filter_sample(feed_sample));
        end
      end

      // Each result transaction is checked against the oldest prediction.
      if (result_valid && result_ready) begin
        if (expected_avg_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("unexpected result: average %0d with nothing pending",
                     result_average);
          end
        end else begin
          want = expected_avg_q.pop_front();
          if (result_average !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("average mismatch: expected %0d, got %0d",
                       want, result_average);
            end
          end
        end
      end
    end
    outstanding <= expected_avg_q.size();
    error_count <= errors;
  end

endmodule

>>> tb/running_average_filter_unit_tb.sv
// Drives sample and clear transactions into the filter through bursts with
// random gaps, stalls the result side on a pattern of its own, and reports
// the verdict from the checker's error and outstanding counts.
module running_average_filter_unit_tb;

  localparam int SAMPLE_BITS  = 16;
  localparam int WINDOW_BITS  = 16;
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD    = 400;

  logic clk;
  logic rst;
  logic window_we;
  logic [WINDOW_BITS-1:0] window_data;

  int outstanding;
  int error_count;
  int burst_left;
  bit hold_request;
  bit hold_done;

  raf_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) feed_if ();
  raf_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_if ();

  running_average_filter_unit #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .WINDOW_BITS(WINDOW_BITS)
  ) dut (
    .clk               (clk),
    .rst               (rst),
    .feed              (feed_if),
    .result            (result_if),
    .window_length_we  (window_we),
    .window_length_data(window_data)
  );

  running_average_checker #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .WINDOW_BITS(WINDOW_BITS)
  ) checker_inst (
    .clk               (clk),
    .rst               (rst),
    .feed_valid        (feed_if.valid),
    .feed_ready        (feed_if.ready),
    .feed_command      (feed_if.command),
    .feed_sample       (feed_if.sample),
    .result_valid      (result_if.valid),
    .result_ready      (result_if.ready),
    .result_average    (result_if.average),
    .window_length_we  (window_we),
    .window_length_data(window_data),
    .outstanding       (outstanding),
    .error_count       (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Offers one transaction and returns once it is accepted; the sender
  // drops valid for a random gap at the end of each burst.
  task automatic push_item(input logic cmd, input logic signed [SAMPLE_BITS-1:0] smp);
    int gap;
    feed_if.valid   <= 1'b1;
    feed_if.command <= cmd;
    feed_if.sample  <= smp;
    @(posedge clk);
    while (!feed_if.ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8);
      feed_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 16);
    end
  endtask

  // Waits until every predicted average has come back and the block is idle.
  task automatic settle();
    feed_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WINDOW_BITS-1:0] value);
    window_we   <= 1'b1;
    window_data <= value;
    @(posedge clk);
    window_we   <= 1'b0;
  endtask

  // Mixes extremes, small values and full-range values.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return SAMPLE_BITS'($signed($urandom_range(0, 600)) - 300);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic run_phase(input int count, input int clear_pct);
    logic cmd;
    for (int i = 0; i < count; i++) begin
      cmd = ($urandom_range(0, 99) < clear_pct) ? raf_pkg::CMD_CLEAR
                                                : raf_pkg::CMD_SAMPLE;
      push_item(cmd, pick_sample());
    end
  endtask

  function automatic logic [WINDOW_BITS-1:0] pick_window();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return WINDOW_BITS'($urandom_range(1, 16));
      3:       return WINDOW_BITS'($urandom_range(17, 300));
      default: return WINDOW_BITS'($urandom_range(1, 65535));
    endcase
  endfunction

  // Receiver: ready follows a pattern of random spans, with one long hold-off
  // on request so the filter backs up into its input.
  initial begin
    int span;
    int mode;
    result_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        result_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(1, 60);
        repeat (span) begin
          case (mode)
            0:       result_if.ready <= 1'b1;
            1:       result_if.ready <= 1'($urandom_range(0, 1));
            2:       result_if.ready <= ($urandom_range(0, 3) != 0);
            default: result_if.ready <= 1'b0;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst             <= 1'b1;
    window_we       <= 1'b0;
    window_data     <= '0;
    feed_if.valid   <= 1'b0;
    feed_if.command <= raf_pkg::CMD_SAMPLE;
    feed_if.sample  <= '0;
    hold_request    = 1'b0;
    hold_done       = 1'b0;
    burst_left      = $urandom_range(1, 16);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset window of eight: overflow of the window with
    // the largest sample, the most negative sample, truncation toward zero
    // around zero, clears with a nonzero sample field and back to back.
    for (int i = 0; i < 9; i++) push_item(raf_pkg::CMD_SAMPLE, 16'sh7FFF);
    for (int i = 0; i < 3; i++) push_item(raf_pkg::CMD_SAMPLE, 16'sh8000);
    push_item(raf_pkg::CMD_CLEAR, 16'sh1234);
    push_item(raf_pkg::CMD_SAMPLE, -16'sd1);
    push_item(raf_pkg::CMD_SAMPLE, 16'sd0);
    push_item(raf_pkg::CMD_SAMPLE, 16'sd1);
    push_item(raf_pkg::CMD_CLEAR, 16'sh8000);
    push_item(raf_pkg::CMD_CLEAR, 16'sh7FFF);
    push_item(raf_pkg::CMD_SAMPLE, 16'sh8000);
    push_item(raf_pkg::CMD_SAMPLE, 16'sh7FFF);
    push_item(raf_pkg::CMD_SAMPLE, 16'sh5555);
    push_item(raf_pkg::CMD_SAMPLE, 16'shAAAA);
    settle();

    // A window written as zero behaves as one.
    write_window('0);
    run_phase(60, 4);
    settle();

    // Widest window with no clears; the receiver holds off meanwhile.
    hold_request = 1'b1;
    write_window('1);
    run_phase(150, 0);
    settle();

    // Lowering the window while many samples are held.
    write_window(WINDOW_BITS'(3));
    run_phase(60, 4);
    settle();

    // Random windows, kept across phases so the count is often trimmed.
    for (int p = 0; p < 8; p++) begin
      write_window(pick_window());
      run_phase(110, 4);
      settle();
    end

    if (error_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
src/raf_pkg.sv
src/raf_in_if.sv
src/raf_out_if.sv
src/raf_divider.sv
src/raf_msub.sv
src/running_average_filter_unit.sv
tb/running_average_checker.sv
tb/running_average_filter_unit_tb.sv
